// ===== rtl/dea_pkg.sv =====
package dea_pkg;

    localparam int DEF_MAX_EXTENTS = 64;
    localparam int DEF_BLOCK_BITS  = 16;
    localparam int ID_W            = 16;
    localparam int CNT_W           = 16;
    localparam logic [CNT_W-1:0] DISK_RESET = 16'd1024;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_DELETE  = 2'd1;
    localparam logic [1:0] FUNC_SHOW    = 2'd2;
    localparam logic [1:0] FUNC_COMPACT = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ERROR      = 2'd1;
    localparam logic [1:0] ST_DISK_FULL  = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

endpackage

// ===== rtl/dea_mem.sv =====
// Simple dual-port table memory, registered read.
module dea_mem #(
    parameter int AW = 7,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/disk_extent_allocator_unit.sv =====
// A write takes two table passes; show, delete and compact take one.
// Throughput: one item at a time; the single read port of the table memory
//   sets the pace at one table entry per cycle when no stall holds the scan.
// Reset (rst_n, async, active low): empty table, disk of 1024 blocks, all free.
module disk_extent_allocator_unit import dea_pkg::*; #(
    parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
    parameter int BLOCK_BITS  = DEF_BLOCK_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // file_id[15:0], block_count[31:16]
    input  logic [1:0]       s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // fragment_start[15:0]
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int B  = BLOCK_BITS;
    localparam int XW = ((B > CNT_W) ? B : CNT_W) + 2;   // gap / count arithmetic
    localparam int IW = $clog2(MAX_EXTENTS + 1);          // entry counts
    localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int DW = ID_W + 2 * B;                      // owner | first | final

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_END    = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;   // write: status check between passes

    // The table lives in two banks of one memory: a pass that edits the table reads the
    // current bank and streams the edited table into the other one, then flips.
    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic [CNT_W-1:0] size_reg, size_next;
    logic             pass2_reg, pass2_next;
    logic             cur_reg, cur_next;
    logic [IW-1:0]    total_reg, total_next;
    logic [XW-1:0]    free_reg, free_next;
    logic [CNT_W-1:0] disk_reg, disk_next;
    logic [IW-1:0]    iss_reg, iss_next;
    logic [IW-1:0]    jdx_reg, jdx_next;
    logic             dv_reg, dv_next;
    logic [IW-1:0]    n_reg, n_next;
    logic [XW-1:0]    below_reg, below_next;   // gap floor: previous final + 1
    logic             hit_reg, hit_next;
    logic             whole_reg, whole_next;
    logic [IW-1:0]    fit_reg, fit_next;
    logic [XW-1:0]    left_reg, left_next;
    logic [IW:0]      pieces_reg, pieces_next;
    logic             ins_reg, ins_next;
    // tail extent for compact, pending fragment start for show
    logic             tv_reg, tv_next;
    logic [ID_W-1:0]  tow_reg, tow_next;
    logic [B-1:0]     tfi_reg, tfi_next;
    logic [B-1:0]     tfn_reg, tfn_next;
    logic             ov_reg, ov_next;
    logic [1:0]       ost_reg, ost_next;
    logic [15:0]      ofs_reg, ofs_next;
    logic             olast_reg, olast_next;

    logic          mem_we, mem_re;
    logic [AW:0]   mem_waddr, mem_raddr;
    logic [DW-1:0] mem_wdata, mem_rdata;

    dea_mem #(.AW(AW + 1), .DW(DW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    logic [ID_W-1:0] e_owner;
    logic [B-1:0]    e_first, e_final, len, s_c;
    logic            is_end, out_free, stall, here;
    logic [XW-1:0]   above, gap, take;
    logic [IW+1:0]   need;
    logic [1:0]      err;

    assign e_owner  = mem_rdata[DW-1:2*B];
    assign e_first  = mem_rdata[2*B-1:B];
    assign e_final  = mem_rdata[B-1:0];
    assign is_end   = (state_reg == S_END);
    assign out_free = !ov_reg || m_tready;
    assign above    = is_end ? XW'(disk_reg) : XW'(e_first);
    assign gap      = (above >= below_reg) ? (above - below_reg) : '0;
    assign here     = whole_reg ? (jdx_reg == fit_reg) : ((gap != '0) && (left_reg != '0));
    assign take     = (gap < left_reg) ? gap : left_reg;
    assign len      = e_final - e_first;
    assign s_c      = tv_reg ? (tfn_reg + B'(1)) : '0;
    assign need     = (IW + 2)'(total_reg) + (whole_reg ? (IW + 2)'(1) : (IW + 2)'(pieces_reg));

    always_comb
    begin
        if ((op_reg == FUNC_WRITE) && (hit_reg || size_reg == '0))
        begin
            err = ST_ERROR;
        end
        else if (XW'(size_reg) > free_reg)
        begin
            err = ST_DISK_FULL;
        end
        else if (need > (IW + 2)'(MAX_EXTENTS))
        begin
            err = ST_TABLE_FULL;
        end
        else
        begin
            err = ST_OK;
        end
    end

    // stall: the current step needs the output slot or the write port again
    always_comb
    begin
        stall = 1'b0;
        if (state_reg == S_SCAN && dv_reg)
        begin
            case (op_reg)
                FUNC_WRITE:   stall = pass2_reg && here && !ins_reg;
                FUNC_SHOW:    stall = (e_owner == id_reg) && tv_reg && !out_free;
                default:      stall = 1'b0;
            endcase
        end
    end

    assign mem_re    = (state_reg == S_SCAN) && (iss_reg < total_reg) && (!dv_reg || !stall);
    assign mem_raddr = {cur_reg, iss_reg[AW-1:0]};
    assign mem_waddr = {~cur_reg, n_reg[AW-1:0]};

    always_comb
    begin
        state_next = state_reg;  op_next = op_reg;  id_next = id_reg;
        size_next = size_reg;    pass2_next = pass2_reg;  cur_next = cur_reg;
        total_next = total_reg;  free_next = free_reg;    disk_next = disk_reg;
        iss_next = iss_reg;      jdx_next = jdx_reg;      n_next = n_reg;
        below_next = below_reg;  hit_next = hit_reg;      whole_next = whole_reg;
        fit_next = fit_reg;      left_next = left_reg;    pieces_next = pieces_reg;
        ins_next = ins_reg;      tv_next = tv_reg;        tow_next = tow_reg;
        tfi_next = tfi_reg;      tfn_next = tfn_reg;
        ov_next = ov_reg && !m_tready;
        ost_next = ost_reg;      ofs_next = ofs_reg;      olast_next = olast_reg;
        mem_we = 1'b0;
        mem_wdata = {e_owner, e_first, e_final};
        dv_next = mem_re || (dv_reg && stall);
        if (mem_re)
        begin
            iss_next = iss_reg + IW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    disk_next  = cfg_data;
                    free_next  = XW'(cfg_data);
                    total_next = '0;
                end
                else if (s_tvalid)
                begin
                    state_next = S_SCAN;
                    op_next = s_tuser;  id_next = s_tdata[15:0];  size_next = s_tdata[31:16];
                    pass2_next = 1'b0;  iss_next = '0;  jdx_next = '0;  n_next = '0;
                    below_next = '0;    hit_next = 1'b0;  whole_next = 1'b0;
                    fit_next = '0;      left_next = XW'(s_tdata[31:16]);
                    pieces_next = '0;   ins_next = 1'b0;  tv_next = 1'b0;
                end
            end

            S_SCAN:
            begin
                if (dv_reg)
                begin
                    case (op_reg)
                        FUNC_WRITE:
                        begin
                            if (!pass2_reg)
                            begin
                                if (e_owner == id_reg)
                                begin
                                    hit_next = 1'b1;
                                end
                                if (!whole_reg && gap >= XW'(size_reg))
                                begin
                                    whole_next = 1'b1;
                                    fit_next   = jdx_reg;
                                end
                                if (left_reg != '0 && gap != '0)
                                begin
                                    pieces_next = pieces_reg + (IW + 1)'(1);
                                    left_next   = (gap >= left_reg) ? '0 : (left_reg - gap);
                                end
                            end
                            else if (here && !ins_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {id_reg, below_reg[B-1:0], B'(below_reg + take - XW'(1))};
                                n_next    = n_reg + IW'(1);
                                left_next = left_reg - take;
                                ins_next  = 1'b1;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                n_next   = n_reg + IW'(1);
                                ins_next = 1'b0;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (e_owner == id_reg)
                            begin
                                hit_next  = 1'b1;
                                free_next = free_reg + XW'(len) + XW'(1);
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                n_next = n_reg + IW'(1);
                            end
                        end
                        FUNC_SHOW:
                        begin
                            if (e_owner == id_reg && !stall)
                            begin
                                if (tv_reg)
                                begin
                                    ov_next = 1'b1;  ost_next = ST_OK;
                                    ofs_next = 16'(tfi_reg);  olast_next = 1'b0;
                                end
                                tv_next  = 1'b1;
                                tfi_next = e_first;
                            end
                        end
                        default:
                        begin
                            if (tv_reg && tow_reg == e_owner)
                            begin
                                tfn_next = s_c + len;
                            end
                            else
                            begin
                                if (tv_reg)
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = {tow_reg, tfi_reg, tfn_reg};
                                    n_next    = n_reg + IW'(1);
                                end
                                tv_next  = 1'b1;
                                tow_next = e_owner;
                                tfi_next = s_c;
                                tfn_next = s_c + len;
                            end
                        end
                    endcase
                    if (!stall)
                    begin
                        jdx_next   = jdx_reg + IW'(1);
                        below_next = XW'(e_final) + XW'(1);
                    end
                end
                if (!mem_re && iss_reg == total_reg && (!dv_reg || !stall))
                begin
                    state_next = S_END;
                end
            end

            S_END:
            begin
                case (op_reg)
                    FUNC_WRITE:
                    begin
                        if (!pass2_reg)
                        begin
                            // account for the gap above the last extent
                            if (!whole_reg && gap >= XW'(size_reg))
                            begin
                                whole_next = 1'b1;
                                fit_next   = jdx_reg;
                            end
                            if (left_reg != '0 && gap != '0)
                            begin
                                pieces_next = pieces_reg + (IW + 1)'(1);
                            end
                            // status is settled in the next cycle
                            pass2_next = 1'b1;
                            state_next = S_DECIDE;
                        end
                        else if (here && !hit_reg)
                        begin
                            // second pass finished: place a final piece, then answer
                            mem_we    = 1'b1;
                            mem_wdata = {id_reg, below_reg[B-1:0], B'(below_reg + take - XW'(1))};
                            n_next    = n_reg + IW'(1);
                            left_next = left_reg - take;
                            hit_next  = 1'b1;
                        end
                        else if (out_free)
                        begin
                            ov_next = 1'b1;  ost_next = ST_OK;  ofs_next = '0;  olast_next = 1'b1;
                            cur_next   = ~cur_reg;
                            total_next = n_reg;
                            free_next  = free_reg - XW'(size_reg);
                            state_next = S_IDLE;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (out_free)
                        begin
                            ov_next = 1'b1;  ofs_next = '0;  olast_next = 1'b1;
                            ost_next   = hit_reg ? ST_OK : ST_ERROR;
                            cur_next   = ~cur_reg;
                            total_next = n_reg;
                            state_next = S_IDLE;
                        end
                    end
                    FUNC_SHOW:
                    begin
                        if (out_free)
                        begin
                            ov_next = 1'b1;  olast_next = 1'b1;
                            ost_next = tv_reg ? ST_OK : ST_ERROR;
                            ofs_next = tv_reg ? 16'(tfi_reg) : '0;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            if (tv_reg)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {tow_reg, tfi_reg, tfn_reg};
                            end
                            ov_next = 1'b1;  ost_next = ST_OK;  ofs_next = '0;  olast_next = 1'b1;
                            cur_next   = ~cur_reg;
                            total_next = n_reg + (tv_reg ? IW'(1) : IW'(0));
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_DECIDE:
            begin
                // reject here, or start the second pass that rebuilds the table
                if (err != ST_OK)
                begin
                    if (out_free)
                    begin
                        ov_next = 1'b1;  ost_next = err;  ofs_next = '0;  olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                    iss_next = '0;  jdx_next = '0;  n_next = '0;  below_next = '0;
                    left_next = XW'(size_reg);  ins_next = 1'b0;  dv_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= 1'b0;
            total_reg <= '0;
            free_reg  <= XW'(DISK_RESET);
            disk_reg  <= DISK_RESET;
            dv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            pass2_reg <= 1'b0;
            ins_reg   <= 1'b0;
            tv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            whole_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            total_reg <= total_next;
            free_reg  <= free_next;
            disk_reg  <= disk_next;
            dv_reg    <= dv_next;
            ov_reg    <= ov_next;
            pass2_reg <= pass2_next;
            ins_reg   <= ins_next;
            tv_reg    <= tv_next;
            hit_reg   <= hit_next;
            whole_reg <= whole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        size_reg   <= size_next;
        iss_reg    <= iss_next;
        jdx_reg    <= jdx_next;
        n_reg      <= n_next;
        below_reg  <= below_next;
        fit_reg    <= fit_next;
        left_reg   <= left_next;
        pieces_reg <= pieces_next;
        tow_reg    <= tow_next;
        tfi_reg    <= tfi_next;
        tfn_reg    <= tfn_next;
        ost_reg    <= ost_next;
        ofs_reg    <= ofs_next;
        olast_reg  <= olast_next;
    end

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tuser   = ost_reg;
    assign m_tdata   = ofs_reg;
    assign m_tlast   = olast_reg;

    // no new item while a command is in flight
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("item accepted while busy");

    // table never grows past its capacity
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= IW'(MAX_EXTENTS))
        else $error("extent count overflow");

    // a read result only shows up during a scan
    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == S_SCAN))
        else $error("table read outside scan");

    // the write port never runs past the table end
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (n_reg < IW'(MAX_EXTENTS)))
        else $error("table write out of range");

endmodule

// ===== sim/disk_extent_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module disk_extent_allocator_unit_tb;
    import dea_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_EXTENTS;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] file_id;
        logic [15:0] block_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frag_start;
        logic        last;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // file_id[15:0], block_count[31:16]
    logic [1:0]  s_tuser;    // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // fragment_start[15:0]
    logic [1:0]  m_tuser;    // status[1:0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    disk_extent_allocator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow allocator state
    logic [15:0] disk_size;
    logic [15:0] ext_owner [TABLE_DEPTH];
    logic [15:0] ext_first [TABLE_DEPTH];
    logic [15:0] ext_last  [TABLE_DEPTH];
    int          ext_count;
    longint      blocks_free;

    cmd_t   cmd_queue[$];
    reply_t reply_queue[$];
    int     fail_count;
    int     idle_cycles;
    bit     calm;            // no idling on either side while set

    // Handshake seen at the last rising edge; the driver reads it at the falling edge.
    logic s_tready_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint gap_lo(int j);
        return (j == 0) ? -1 : longint'(ext_last[j-1]);
    endfunction

    function automatic longint gap_hi(int j);
        return (j >= ext_count) ? longint'(disk_size) : longint'(ext_first[j]);
    endfunction

    function automatic longint gap_len(int j);
        longint g;
        g = gap_hi(j) - gap_lo(j) - 1;
        return (g < 0) ? 0 : g;
    endfunction

    function automatic void format_disk(logic [15:0] size);
        disk_size   = size;
        ext_count   = 0;
        blocks_free = size;
    endfunction

    function automatic void add_reply(reply_t r);
        reply_queue.insert(reply_queue.size(), r);
    endfunction

    function automatic logic [1:0] alloc_write(logic [15:0] id, logic [15:0] size);
        logic [15:0] n_owner [TABLE_DEPTH];
        logic [15:0] n_first [TABLE_DEPTH];
        logic [15:0] n_last  [TABLE_DEPTH];
        int     n;
        int     fit;
        int     pieces;
        bit     whole;
        bit     here;
        longint left;
        longint g;
        longint take;
        longint s;
        n = 0;
        fit = 0;
        pieces = 0;
        whole = 0;
        for (int i = 0; i < ext_count; i++)
            if (ext_owner[i] == id)
                return ST_ERROR;
        if (size == 0)
            return ST_ERROR;
        if (longint'(size) > blocks_free)
            return ST_DISK_FULL;
        for (int j = 0; j <= ext_count; j++)
            if (!whole && gap_len(j) >= size)
            begin
                whole = 1;
                fit = j;
            end
        if (whole)
            pieces = 1;
        else
        begin
            left = size;
            for (int j = 0; j <= ext_count && left > 0; j++)
            begin
                g = gap_len(j);
                if (g > 0)
                begin
                    pieces++;
                    left -= g;
                end
            end
        end
        if (ext_count + pieces > TABLE_DEPTH)
            return ST_TABLE_FULL;
        left = size;
        for (int j = 0; j <= ext_count; j++)
        begin
            g = gap_len(j);
            here = whole ? (j == fit) : (g > 0 && left > 0);
            if (here)
            begin
                take = (g < left) ? g : left;
                s = gap_lo(j) + 1;
                n_owner[n] = id;
                n_first[n] = s[15:0];
                n_last[n]  = 16'(s + take - 1);
                n++;
                left -= take;
            end
            if (j < ext_count)
            begin
                n_owner[n] = ext_owner[j];
                n_first[n] = ext_first[j];
                n_last[n]  = ext_last[j];
                n++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            ext_owner[i] = n_owner[i];
            ext_first[i] = n_first[i];
            ext_last[i]  = n_last[i];
        end
        ext_count = n;
        blocks_free -= size;
        return ST_OK;
    endfunction

    function automatic logic [1:0] alloc_delete(logic [15:0] id);
        int n;
        bit found;
        n = 0;
        found = 0;
        for (int i = 0; i < ext_count; i++)
        begin
            if (ext_owner[i] == id)
            begin
                blocks_free += ext_last[i] - ext_first[i] + 1;
                found = 1;
            end
            else
            begin
                ext_owner[n] = ext_owner[i];
                ext_first[n] = ext_first[i];
                ext_last[n]  = ext_last[i];
                n++;
            end
        end
        ext_count = n;
        return found ? ST_OK : ST_ERROR;
    endfunction

    function automatic void alloc_compact();
        int n;
        logic [15:0] len;
        logic [15:0] s;
        n = 0;
        for (int i = 0; i < ext_count; i++)
        begin
            len = ext_last[i] - ext_first[i];
            s = (n == 0) ? 16'd0 : ext_last[n-1] + 16'd1;
            if (n > 0 && ext_owner[n-1] == ext_owner[i])
                ext_last[n-1] = s + len;
            else
            begin
                ext_owner[n] = ext_owner[i];
                ext_first[n] = s;
                ext_last[n]  = s + len;
                n++;
            end
        end
        ext_count = n;
    endfunction

    // Applies one accepted command to the shadow table, queues its replies.
    function automatic void predict_replies(cmd_t c);
        reply_t r;
        int k;
        k = 0;
        case (c.func)
            FUNC_WRITE:
            begin
                r = '{alloc_write(c.file_id, c.block_count), 16'd0, 1'b1};
                add_reply(r);
            end
            FUNC_DELETE:
            begin
                r = '{alloc_delete(c.file_id), 16'd0, 1'b1};
                add_reply(r);
            end
            FUNC_SHOW:
            begin
                for (int i = 0; i < ext_count; i++)
                    if (ext_owner[i] == c.file_id)
                    begin
                        if (k > 0)
                            reply_queue[$].last = 1'b0;
                        r = '{ST_OK, ext_first[i], 1'b1};
                        add_reply(r);
                        k++;
                    end
                if (k == 0)
                begin
                    r = '{ST_ERROR, 16'd0, 1'b1};
                    add_reply(r);
                end
            end
            default:
            begin
                alloc_compact();
                r = '{ST_OK, 16'd0, 1'b1};
                add_reply(r);
            end
        endcase
    endfunction

    // Driver: presents queued commands, changes at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready_seen)
            begin
                if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 8))
                begin
                    s_tvalid <= 1'b1;
                    {s_tuser, s_tdata} <= {cmd_queue[0].func, cmd_queue[0].block_count,
                                           cmd_queue[0].file_id};
                    void'(cmd_queue.pop_front());
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid && cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 8))
            begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= {cmd_queue[0].func, cmd_queue[0].block_count,
                                       cmd_queue[0].file_id};
                void'(cmd_queue.pop_front());
            end
            m_tready <= calm || ($urandom_range(99) >= 8);
        end
    end

    // Monitor: samples at the rising edge, predicts on input, checks on output.
    always @(posedge clk)
    begin
        s_tready_seen <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
                predict_replies('{s_tuser, s_tdata[15:0], s_tdata[31:16]});
            if (m_tvalid && m_tready)
            begin
                if (reply_queue.size() == 0)
                begin
                    $error("unexpected item: status %0d start %0d last %0d",
                           m_tuser, m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    if (m_tuser !== reply_queue[0].status)
                    begin
                        $error("status: expected %0d actual %0d",
                               reply_queue[0].status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata !== reply_queue[0].frag_start)
                    begin
                        $error("fragment_start: expected %0d actual %0d",
                               reply_queue[0].frag_start, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== reply_queue[0].last)
                    begin
                        $error("last: expected %0d actual %0d",
                               reply_queue[0].last, m_tlast);
                        fail_count++;
                    end
                    void'(reply_queue.pop_front());
                end
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Waits until all commands are taken and every reply is back.
    task automatic drain();
        while (cmd_queue.size() > 0 || s_tvalid || reply_queue.size() > 0)
            @(posedge clk);
        repeat (2 * TABLE_DEPTH + 20) @(posedge clk);
    endtask

    // Reformats the disk; only called with the block idle.
    task automatic set_disk_size(logic [15:0] size);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (!cfg_ready);
        format_disk(size);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void queue_cmd(logic [1:0] f, logic [15:0] id, logic [15:0] n);
        cmd_t c;
        c = '{f, id, n};
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    // Mostly writes of live-ish ids, deletes and shows of those ids.
    task automatic random_phase(int count, int id_span, int size_max);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                queue_cmd(FUNC_WRITE, 16'($urandom_range(id_span)),
                          16'($urandom_range(size_max, 1)));
            else if (pick < 65)
                queue_cmd(FUNC_DELETE, 16'($urandom_range(id_span)), 16'($urandom));
            else if (pick < 85)
                queue_cmd(FUNC_SHOW, 16'($urandom_range(id_span)), 16'($urandom));
            else if (pick < 93)
                queue_cmd(FUNC_COMPACT, 16'($urandom), 16'($urandom));
            else
                queue_cmd(2'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        fail_count  = 0;
        idle_cycles = 0;
        calm        = 1'b0;
        format_disk(DISK_RESET);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset-size disk, fragments, errors, compaction
        queue_cmd(FUNC_SHOW, 16'd5, 16'd0);           // unknown id
        queue_cmd(FUNC_DELETE, 16'd5, 16'd0);
        queue_cmd(FUNC_WRITE, 16'd0, 16'd0);          // zero length
        queue_cmd(FUNC_WRITE, 16'd1, 16'd100);
        queue_cmd(FUNC_WRITE, 16'd1, 16'd5);          // duplicate
        queue_cmd(FUNC_WRITE, 16'hFFFF, 16'd200);
        queue_cmd(FUNC_WRITE, 16'd3, 16'd50);
        queue_cmd(FUNC_WRITE, 16'd4, 16'hFFFF);       // disk full
        queue_cmd(FUNC_DELETE, 16'd1, 16'd0);
        queue_cmd(FUNC_DELETE, 16'd3, 16'd0);
        queue_cmd(FUNC_WRITE, 16'd7, 16'd700);        // fits whole in the upper gap
        queue_cmd(FUNC_SHOW, 16'd7, 16'd0);
        queue_cmd(FUNC_SHOW, 16'hFFFF, 16'd0);
        queue_cmd(FUNC_COMPACT, 16'd0, 16'd0);
        queue_cmd(FUNC_SHOW, 16'd7, 16'd0);
        queue_cmd(FUNC_WRITE, 16'd8, 16'd74);         // leaves 50 blocks free
        queue_cmd(FUNC_WRITE, 16'd9, 16'd1);
        queue_cmd(FUNC_DELETE, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_SHOW, 16'd8, 16'd0);
        drain();

        // table full: 64 two-block files with holes, then a fragmented write
        set_disk_size(16'd130);
        calm = 1'b1;
        for (int i = 0; i < 64; i++)
            queue_cmd(FUNC_WRITE, 16'(100 + i), 16'd2);
        for (int i = 0; i < 64; i += 2)
            queue_cmd(FUNC_DELETE, 16'(100 + i), 16'd0);
        queue_cmd(FUNC_WRITE, 16'd1, 16'd66);         // too many pieces
        queue_cmd(FUNC_WRITE, 16'd2, 16'd40);
        queue_cmd(FUNC_SHOW, 16'd2, 16'd0);           // long show burst
        queue_cmd(FUNC_COMPACT, 16'd0, 16'd0);
        queue_cmd(FUNC_SHOW, 16'd2, 16'd0);
        drain();
        calm = 1'b0;

        // random phases over several disk sizes, including the extremes
        set_disk_size(16'd1);
        random_phase(8, 3, 2);
        drain();
        set_disk_size(16'd0);
        random_phase(6, 3, 3);
        drain();
        set_disk_size(16'd300);
        random_phase(16, 15, 60);
        drain();
        set_disk_size(16'hFFFF);
        calm = 1'b1;
        random_phase(8, 20, 65535);
        drain();
        calm = 1'b0;
        set_disk_size(16'd2000);
        random_phase(12, 40, 120);
        drain();

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
